// ===== src/dnv_pkg.sv =====
`default_nettype none
package dnv_pkg;

   localparam int unsigned TOTAL_W = 9;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned LABEL_W = 7;

   localparam logic [TOTAL_W-1:0] TOTAL_SAT = 9'd511;
   localparam logic [TOTAL_W-1:0] TOTAL_MIN = 9'd3;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 9'd255;
   localparam logic [COUNT_W-1:0] COUNT_SAT = 4'd15;
   // dots closed before the root label: labels = dots + 1
   localparam logic [COUNT_W-1:0] DOTS_MIN  = 4'd1;
   localparam logic [COUNT_W-1:0] DOTS_MAX  = 4'd7;
   localparam logic [COUNT_W-1:0] DOTS_SLD  = 4'd1;
   localparam logic [LABEL_W-1:0] LABEL_SAT = 7'd127;
   localparam logic [LABEL_W-1:0] LABEL_MAX = 7'd63;
   localparam logic [LABEL_W-1:0] ROOT_MAX  = 7'd16;

   localparam logic [7:0] CHAR_HYPHEN  = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   localparam logic [1:0] MODE_FULL   = 2'd0;
   localparam logic [1:0] MODE_SECOND = 2'd1;
   localparam logic [1:0] MODE_ROOT   = 2'd2;
   localparam int unsigned MODE_ROOT_BIT = 1;

   typedef struct packed {
      logic alpha;
      logic alnum;
      logic hyphen;
      logic dot;
   } char_class_type;

endpackage
`default_nettype wire

// ===== src/dnv_char_class.sv =====
`default_nettype none
module dnv_char_class (
   input  wire logic [7:0]              char_byte,
   output dnv_pkg::char_class_type      char_class
);

   logic is_upper;
   logic is_lower;
   logic is_digit;

   always_comb begin
      is_upper = (char_byte >= dnv_pkg::CHAR_UPPER_A) && (char_byte <= dnv_pkg::CHAR_UPPER_Z);
      is_lower = (char_byte >= dnv_pkg::CHAR_LOWER_A) && (char_byte <= dnv_pkg::CHAR_LOWER_Z);
      is_digit = (char_byte >= dnv_pkg::CHAR_DIGIT_0) && (char_byte <= dnv_pkg::CHAR_DIGIT_9);
      char_class.alpha  = is_upper | is_lower;
      char_class.alnum  = is_upper | is_lower | is_digit;
      char_class.hyphen = (char_byte == dnv_pkg::CHAR_HYPHEN);
      char_class.dot    = (char_byte == dnv_pkg::CHAR_DOT);
   end

endmodule
`default_nettype wire

// ===== src/dotted_name_validator.sv =====
`default_nettype none
// The verdict is valid in the cycle after the final byte of a name is accepted.
// One byte per cycle while req_tready is high; per-name state updates per byte.
// A request is taken while a verdict waits, as long as the output register drains.
// Reset (synchronous, active high) clears all name state, the output valid and
// sets check_mode to full-name mode.
module dotted_name_validator (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_wdata,   // check_mode
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_byte
   input  wire logic       req_tlast,   // last_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [0] name_valid, [7:1] zero
);

   logic [1:0]                    mode_ff;
   logic [dnv_pkg::TOTAL_W-1:0]   total_ff, total_in;
   logic [dnv_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [dnv_pkg::LABEL_W-1:0]   len_ff, len_in;
   logic                          first_alpha_ff, first_alpha_in;
   logic                          first_alnum_ff, first_alnum_in;
   logic                          prev_alnum_ff, prev_alnum_in;
   logic                          failed_ff, failed_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          verdict_ff, verdict_in;

   dnv_pkg::char_class_type       cls;
   logic                          accept;
   logic                          root_mode;
   logic                          ok;

   dnv_char_class u_class (
      .char_byte  (req_tdata),
      .char_class (cls)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign root_mode  = mode_ff[dnv_pkg::MODE_ROOT_BIT];

   always_comb begin
      total_in       = (total_ff != dnv_pkg::TOTAL_SAT) ? total_ff + 9'd1 : total_ff;
      count_in       = count_ff;
      len_in         = len_ff;
      first_alpha_in = first_alpha_ff;
      first_alnum_in = first_alnum_ff;
      prev_alnum_in  = prev_alnum_ff;
      failed_in      = failed_ff;

      if (cls.dot && !root_mode) begin
         // a final dot leaves the current label as the root label
         if (!req_tlast) begin
            if ((len_ff == '0) || (len_ff > dnv_pkg::LABEL_MAX) ||
                !first_alnum_ff || !prev_alnum_ff) begin
               failed_in = 1'b1;
            end
            if (count_ff != dnv_pkg::COUNT_SAT) begin
               count_in = count_ff + 4'd1;
            end
            len_in         = '0;
            first_alpha_in = 1'b0;
            first_alnum_in = 1'b0;
            prev_alnum_in  = 1'b0;
         end
      end else begin
         if (!cls.alnum && !cls.hyphen) begin
            failed_in = 1'b1;
         end
         if (len_ff == '0) begin
            first_alpha_in = cls.alpha;
            first_alnum_in = cls.alnum;
         end
         if (len_ff != dnv_pkg::LABEL_SAT) begin
            len_in = len_ff + 7'd1;
         end
         prev_alnum_in = cls.alnum;
      end

      ok = !failed_in && (len_in != '0) && (len_in <= dnv_pkg::ROOT_MAX) &&
           first_alpha_in && prev_alnum_in;
      if (!root_mode) begin
         if ((total_in < dnv_pkg::TOTAL_MIN) || (total_in > dnv_pkg::TOTAL_MAX)) begin
            ok = 1'b0;
         end
         if ((count_in < dnv_pkg::DOTS_MIN) || (count_in > dnv_pkg::DOTS_MAX)) begin
            ok = 1'b0;
         end
         if ((mode_ff == dnv_pkg::MODE_SECOND) && (count_in != dnv_pkg::DOTS_SLD)) begin
            ok = 1'b0;
         end
      end
      verdict_in = ok;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept && req_tlast) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= dnv_pkg::MODE_FULL;
         total_ff       <= '0;
         count_ff       <= '0;
         len_ff         <= '0;
         first_alpha_ff <= 1'b0;
         first_alnum_ff <= 1'b0;
         prev_alnum_ff  <= 1'b0;
         failed_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_tlast) begin
               total_ff       <= '0;
               count_ff       <= '0;
               len_ff         <= '0;
               first_alpha_ff <= 1'b0;
               first_alnum_ff <= 1'b0;
               prev_alnum_ff  <= 1'b0;
               failed_ff      <= 1'b0;
            end else begin
               total_ff       <= total_in;
               count_ff       <= count_in;
               len_ff         <= len_in;
               first_alpha_ff <= first_alpha_in;
               first_alnum_ff <= first_alnum_in;
               prev_alnum_ff  <= prev_alnum_in;
               failed_ff      <= failed_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tlast) begin
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, verdict_ff};

   // final byte yields a verdict and clears the name state
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> rsp_valid_ff && (total_ff == '0) && (count_ff == '0) &&
                              (len_ff == '0) && !failed_ff)
      else $error("final byte did not post a verdict and clear state");

   // a non-final byte is counted and leaves no verdict behind
   a_mid_counts: assert property (@(posedge clock) disable iff (reset)
      accept && !req_tlast && !(rsp_valid_ff && !rsp_tready) |=>
         (total_ff != '0) && !rsp_valid_ff)
      else $error("non-final byte mishandled");

   // root mode never closes a label on a dot
   a_root_no_count: assert property (@(posedge clock) disable iff (reset)
      accept && !req_tlast && root_mode |=> count_ff == $past(count_ff))
      else $error("label count moved in root mode");

   // a broken rule sticks until the name ends
   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      failed_ff && !(accept && req_tlast) |=> failed_ff)
      else $error("failure flag dropped mid-name");

endmodule
`default_nettype wire
